FILE: rtl/cpde_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpde_pkg
// Shared types, widths and the multiply step table for the polynomial
// derivative evaluator.
// ----------------------------------------------------------------------------
package cpde_pkg;

  localparam int MAX_DEGREE_DEF = 20;

  localparam int COEFF_W   = 32;
  localparam int VALUE_W   = 64;
  localparam int CFG_W     = 5;
  localparam int CFG_IDX_W = 2;
  localparam int FF_W      = 62;
  localparam int OPND_W    = 33;
  localparam int PROD_W    = 2 * OPND_W;
  localparam int SUM_W     = 128;
  localparam int STEP_W    = 4;
  localparam int FRAC_SH   = 16;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_POLY_DEGREE = 2'd0;
  localparam cfg_idx_t CFG_DERIV_ORDER = 2'd1;

  localparam logic [VALUE_W-1:0] VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam logic [VALUE_W-1:0] VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

  localparam logic [STEP_W-1:0] FF_FIRST_STEP = 4'd8;
  localparam logic [STEP_W-1:0] LAST_STEP     = 4'd9;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  typedef enum logic [2:0] {
    A_RE_LO,
    A_RE_HI,
    A_IM_LO,
    A_IM_HI,
    A_COEFF
  } a_sel_t;

  typedef enum logic [1:0] {
    B_ZRE,
    B_ZIM,
    B_FF_LO,
    B_FF_HI
  } b_sel_t;

  typedef enum logic [1:0] {
    SH_0,
    SH_32,
    SH_64
  } shift_t;

  typedef struct packed {
    a_sel_t a_sel;
    b_sel_t b_sel;
    shift_t shift;
    logic   neg;
    logic   to_im;
  } step_op_t;

  typedef struct packed {
    logic              accept;
    logic              issue;
    logic [STEP_W-1:0] step;
    logic              ff_step;
    logic              finish;
  } cmd_t;

  typedef struct packed {
    logic skip;
    logic last;
    logic ff_done;
  } sts_t;

  // re += acc_re*zr - acc_im*zi + c*ff<<32 ; im += acc_re*zi + acc_im*zr
  function automatic step_op_t step_op(input logic [STEP_W-1:0] step);
    step_op_t op;
    op = '{a_sel: A_RE_LO, b_sel: B_ZRE, shift: SH_0, neg: 1'b0, to_im: 1'b0};
    case (step)
      4'd0: op = '{a_sel: A_RE_LO, b_sel: B_ZRE,   shift: SH_0,  neg: 1'b0, to_im: 1'b0};
      4'd1: op = '{a_sel: A_RE_HI, b_sel: B_ZRE,   shift: SH_32, neg: 1'b0, to_im: 1'b0};
      4'd2: op = '{a_sel: A_IM_LO, b_sel: B_ZIM,   shift: SH_0,  neg: 1'b1, to_im: 1'b0};
      4'd3: op = '{a_sel: A_IM_HI, b_sel: B_ZIM,   shift: SH_32, neg: 1'b1, to_im: 1'b0};
      4'd4: op = '{a_sel: A_RE_LO, b_sel: B_ZIM,   shift: SH_0,  neg: 1'b0, to_im: 1'b1};
      4'd5: op = '{a_sel: A_RE_HI, b_sel: B_ZIM,   shift: SH_32, neg: 1'b0, to_im: 1'b1};
      4'd6: op = '{a_sel: A_IM_LO, b_sel: B_ZRE,   shift: SH_0,  neg: 1'b0, to_im: 1'b1};
      4'd7: op = '{a_sel: A_IM_HI, b_sel: B_ZRE,   shift: SH_32, neg: 1'b0, to_im: 1'b1};
      4'd8: op = '{a_sel: A_COEFF, b_sel: B_FF_LO, shift: SH_32, neg: 1'b0, to_im: 1'b0};
      4'd9: op = '{a_sel: A_COEFF, b_sel: B_FF_HI, shift: SH_64, neg: 1'b0, to_im: 1'b0};
      default: op = '{a_sel: A_RE_LO, b_sel: B_ZRE, shift: SH_0, neg: 1'b0, to_im: 1'b0};
    endcase
    return op;
  endfunction

endpackage

FILE: rtl/complex_poly_derivative_eval.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// complex_poly_derivative_eval
// k-th derivative of a real polynomial at a complex point, Horner's method,
// Q16.16 coefficients and point, saturating Q32.32 result.
// ----------------------------------------------------------------------------
// Write poly_degree (index 0) and deriv_order (index 1), then send the N+1
// coefficients highest index first; z is taken from the first word of each
// evaluation and one result word follows the last coefficient. A coefficient
// whose index is below the order is accepted and finished with no partial
// product. Any other needs ten partial products through one shared 33x33
// multiplier, with the falling factorial built one factor a cycle alongside,
// plus accept, drain and saturate steps. One word is in work at a time; the
// result register lets the next evaluation start while a result waits.
// ----------------------------------------------------------------------------
module complex_poly_derivative_eval #(
  parameter int MAX_DEGREE = cpde_pkg::MAX_DEGREE_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [cpde_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [cpde_pkg::CFG_W-1:0]          cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [cpde_pkg::COEFF_W-1:0] coeff,
  input  logic signed [cpde_pkg::COEFF_W-1:0] z_re,
  input  logic signed [cpde_pkg::COEFF_W-1:0] z_im,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [cpde_pkg::VALUE_W-1:0] value_re,
  output logic signed [cpde_pkg::VALUE_W-1:0] value_im,
  output logic                                overflow
);

  cpde_pkg::cmd_t cmd;
  cpde_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  cpde_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  cpde_dp #(
    .MAX_DEGREE (MAX_DEGREE)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .coeff     (coeff),
    .z_re      (z_re),
    .z_im      (z_im),
    .cmd       (cmd),
    .sts       (sts),
    .value_re  (value_re),
    .value_im  (value_im),
    .overflow  (overflow)
  );

endmodule

FILE: rtl/cpde_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpde_ctrl
// Sequencer: accepts a word, steps the shared multiplier through the
// partial products, and hands the finished result to the output register.
// ----------------------------------------------------------------------------
module cpde_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  cpde_pkg::sts_t sts,
  output cpde_pkg::cmd_t cmd
);

  cpde_pkg::state_t                  state;
  cpde_pkg::state_t                  state_next;
  logic [cpde_pkg::STEP_W-1:0]       step;
  logic [cpde_pkg::STEP_W-1:0]       step_next;
  logic                              out_valid_next;
  logic                              out_stall;

  assign out_stall = sts.last && out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= cpde_pkg::ST_IDLE;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      step      <= step_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      cpde_pkg::ST_IDLE: begin
        if (in_valid) state_next = cpde_pkg::ST_CALC;
      end
      cpde_pkg::ST_CALC: begin
        if (sts.skip) state_next = cpde_pkg::ST_FINISH;
        else if (cmd.issue && step == cpde_pkg::LAST_STEP) state_next = cpde_pkg::ST_DRAIN;
      end
      cpde_pkg::ST_DRAIN: begin
        state_next = cpde_pkg::ST_FINISH;
      end
      cpde_pkg::ST_FINISH: begin
        if (!out_stall) state_next = cpde_pkg::ST_IDLE;
      end
      default: state_next = cpde_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    cmd.accept  = 1'b0;
    cmd.issue   = 1'b0;
    cmd.step    = step;
    cmd.ff_step = 1'b0;
    cmd.finish  = 1'b0;
    unique case (state)
      cpde_pkg::ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      cpde_pkg::ST_CALC: begin
        cmd.ff_step = !sts.skip && !sts.ff_done;
        cmd.issue   = !sts.skip && (step < cpde_pkg::FF_FIRST_STEP || sts.ff_done);
      end
      cpde_pkg::ST_DRAIN: begin
      end
      cpde_pkg::ST_FINISH: begin
        cmd.finish = !out_stall;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    step_next = step;
    if (state == cpde_pkg::ST_IDLE) step_next = '0;
    else if (cmd.issue) step_next = step + 1'b1;
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.finish && sts.last) out_valid_next = 1'b1;
    else if (out_ready) out_valid_next = 1'b0;
  end

endmodule

FILE: rtl/cpde_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpde_dp
// Datapath: configuration registers, point and accumulator, falling
// factorial unit, one shared 33x33 multiplier and a 128-bit sum pair.
// ----------------------------------------------------------------------------
module cpde_dp #(
  parameter int MAX_DEGREE = cpde_pkg::MAX_DEGREE_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  input  logic [cpde_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [cpde_pkg::CFG_W-1:0]          cfg_data,
  input  logic signed [cpde_pkg::COEFF_W-1:0] coeff,
  input  logic signed [cpde_pkg::COEFF_W-1:0] z_re,
  input  logic signed [cpde_pkg::COEFF_W-1:0] z_im,
  input  cpde_pkg::cmd_t                      cmd,
  output cpde_pkg::sts_t                      sts,
  output logic signed [cpde_pkg::VALUE_W-1:0] value_re,
  output logic signed [cpde_pkg::VALUE_W-1:0] value_im,
  output logic                                overflow
);

  localparam int CW = cpde_pkg::CFG_W;
  localparam int VW = cpde_pkg::VALUE_W;
  localparam int SW = cpde_pkg::SUM_W;
  localparam int PW = cpde_pkg::PROD_W;
  localparam int OW = cpde_pkg::OPND_W;
  localparam int FW = cpde_pkg::FF_W;
  localparam int FS = cpde_pkg::FRAC_SH;
  localparam logic [CW-1:0] DEG_CAP = CW'(MAX_DEGREE);

  logic [CW-1:0]          poly_degree;
  logic [CW-1:0]          deriv_order;
  logic                   first_item;
  logic [CW-1:0]          coeff_index;
  logic [CW-1:0]          index_start;
  logic [cpde_pkg::COEFF_W-1:0] point_re;
  logic [cpde_pkg::COEFF_W-1:0] point_im;
  logic [cpde_pkg::COEFF_W-1:0] coeff_reg;
  logic [VW-1:0]          acc_re;
  logic [VW-1:0]          acc_im;
  logic                   sat_seen;

  logic [FW-1:0]          scale_factor;
  logic [CW-1:0]          ff_fac;
  logic [CW-1:0]          ff_cnt;
  logic [FW+CW-1:0]       ff_prod;

  cpde_pkg::step_op_t     op;
  cpde_pkg::step_op_t     prod_op;
  logic                   prod_vld;
  logic signed [OW-1:0]   mul_a;
  logic signed [OW-1:0]   mul_b;
  logic signed [PW-1:0]   mul_p;
  logic signed [PW-1:0]   prod;
  logic [SW-1:0]          prod_ext;
  logic [SW-1:0]          prod_sh;
  logic [SW-1:0]          sum_re;
  logic [SW-1:0]          sum_im;
  logic [SW-1:0]          sum_sel;
  logic [SW-1:0]          sum_upd;

  logic                   fit_re;
  logic                   fit_im;
  logic [VW-1:0]          sat_re;
  logic [VW-1:0]          sat_im;
  logic [VW-1:0]          acc_re_new;
  logic [VW-1:0]          acc_im_new;
  logic                   sat_new;

  assign index_start = first_item ? poly_degree : coeff_index;

  assign sts.skip    = coeff_index < deriv_order;
  assign sts.last    = coeff_index == '0;
  assign sts.ff_done = ff_cnt == '0;

  // configuration; a write to poly_degree or deriv_order restarts the evaluation
  always_ff @(posedge clk) begin
    if (rst) begin
      poly_degree <= '0;
      deriv_order <= '0;
      first_item  <= 1'b1;
    end else begin
      if (cmd.accept) first_item <= 1'b0;
      if (cmd.finish && sts.last) first_item <= 1'b1;
      if (cfg_valid) begin
        unique case (cfg_index)
          cpde_pkg::CFG_POLY_DEGREE: begin
            poly_degree <= (cfg_data > DEG_CAP) ? DEG_CAP : cfg_data;
            first_item  <= 1'b1;
          end
          cpde_pkg::CFG_DERIV_ORDER: begin
            deriv_order <= cfg_data;
            first_item  <= 1'b1;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      coeff_index <= '0;
      point_re    <= '0;
      point_im    <= '0;
      acc_re      <= '0;
      acc_im      <= '0;
      sat_seen    <= 1'b0;
    end else if (cmd.accept) begin
      coeff_index <= index_start;
      if (first_item) begin
        point_re <= z_re;
        point_im <= z_im;
        acc_re   <= '0;
        acc_im   <= '0;
        sat_seen <= 1'b0;
      end
    end else if (cmd.finish) begin
      acc_re   <= acc_re_new;
      acc_im   <= acc_im_new;
      sat_seen <= sat_new;
      if (!sts.last) coeff_index <= coeff_index - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) coeff_reg <= coeff;
  end

  // falling factorial j*(j-1)*...*(j-k+1), one factor per cycle
  assign ff_prod = scale_factor * ff_fac;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale_factor <= '0;
      ff_fac       <= '0;
      ff_cnt       <= '0;
    end else if (cmd.accept) begin
      scale_factor <= FW'(1);
      ff_fac       <= index_start;
      ff_cnt       <= deriv_order;
    end else if (cmd.ff_step) begin
      scale_factor <= ff_prod[FW-1:0];
      ff_fac       <= ff_fac - 1'b1;
      ff_cnt       <= ff_cnt - 1'b1;
    end
  end

  // shared multiplier
  assign op = cpde_pkg::step_op(cmd.step);

  always_comb begin
    case (op.a_sel)
      cpde_pkg::A_RE_LO: mul_a = {1'b0, acc_re[31:0]};
      cpde_pkg::A_RE_HI: mul_a = {acc_re[63], acc_re[63:32]};
      cpde_pkg::A_IM_LO: mul_a = {1'b0, acc_im[31:0]};
      cpde_pkg::A_IM_HI: mul_a = {acc_im[63], acc_im[63:32]};
      cpde_pkg::A_COEFF: mul_a = {coeff_reg[31], coeff_reg};
      default:           mul_a = '0;
    endcase
    case (op.b_sel)
      cpde_pkg::B_ZRE:   mul_b = {point_re[31], point_re};
      cpde_pkg::B_ZIM:   mul_b = {point_im[31], point_im};
      cpde_pkg::B_FF_LO: mul_b = {1'b0, scale_factor[31:0]};
      cpde_pkg::B_FF_HI: mul_b = {{(OW-(FW-32)){1'b0}}, scale_factor[FW-1:32]};
      default:           mul_b = '0;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  always_ff @(posedge clk) begin
    if (rst) prod_vld <= 1'b0;
    else     prod_vld <= cmd.issue;
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      prod    <= mul_p;
      prod_op <= op;
    end
  end

  // align and accumulate the registered partial product
  assign prod_ext = {{(SW-PW){prod[PW-1]}}, prod};

  always_comb begin
    case (prod_op.shift)
      cpde_pkg::SH_0:  prod_sh = prod_ext;
      cpde_pkg::SH_32: prod_sh = prod_ext << 32;
      cpde_pkg::SH_64: prod_sh = prod_ext << 64;
      default:         prod_sh = prod_ext;
    endcase
  end

  assign sum_sel = prod_op.to_im ? sum_im : sum_re;
  assign sum_upd = prod_op.neg ? sum_sel - prod_sh : sum_sel + prod_sh;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      sum_re <= '0;
      sum_im <= '0;
    end else if (prod_vld) begin
      if (prod_op.to_im) sum_im <= sum_upd;
      else               sum_re <= sum_upd;
    end
  end

  // floor shift by 16 then saturate to Q32.32
  assign fit_re = (&sum_re[SW-1:VW+FS-1]) | ~(|sum_re[SW-1:VW+FS-1]);
  assign fit_im = (&sum_im[SW-1:VW+FS-1]) | ~(|sum_im[SW-1:VW+FS-1]);
  assign sat_re = fit_re ? sum_re[VW+FS-1:FS]
                         : (sum_re[SW-1] ? cpde_pkg::VALUE_MIN : cpde_pkg::VALUE_MAX);
  assign sat_im = fit_im ? sum_im[VW+FS-1:FS]
                         : (sum_im[SW-1] ? cpde_pkg::VALUE_MIN : cpde_pkg::VALUE_MAX);

  assign acc_re_new = sts.skip ? acc_re : sat_re;
  assign acc_im_new = sts.skip ? acc_im : sat_im;
  assign sat_new    = sat_seen | (!sts.skip & (!fit_re | !fit_im));

  always_ff @(posedge clk) begin
    if (cmd.finish && sts.last) begin
      value_re <= acc_re_new;
      value_im <= acc_im_new;
      overflow <= sat_new;
    end
  end

endmodule
